>>> hdl/stl_pkg.sv
// Shared types, character codes and character-class functions of the script token lexer.
`default_nettype none

package stl_pkg;

    // Lexer phases.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_NAME,
        PH_NUM,
        PH_HEX,
        PH_STR,
        PH_SLASH,
        PH_COMMENT
    } phase_t;

    // Token kinds as they appear on the result channel.
    typedef enum logic [2:0] {
        KIND_SPACE  = 3'd0,
        KIND_NAME   = 3'd1,
        KIND_NUM    = 3'd2,
        KIND_HEX    = 3'd3,
        KIND_STR    = 3'd4,
        KIND_SYM    = 3'd5,
        KIND_END    = 3'd6
    } kind_t;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    // Depth of the result queue; one item can add two results.
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 3;

    // Token state apart from the character count.
    typedef struct packed {
        phase_t      phase;
        logic [7:0]  held_char;
        logic        held_valid;
        logic        held_first;
        kind_t       kind;
        logic [31:0] acc;
    } tok_t;

    localparam tok_t TOK_CLEAR = '{
        phase:      PH_IDLE,
        held_char:  8'h00,
        held_valid: 1'b0,
        held_first: 1'b0,
        kind:       KIND_SPACE,
        acc:        32'h0
    };

    // One result item.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  ch;
        logic        cvalid;
        logic        first;
        logic        last;
        logic [31:0] hexv;
        logic [23:0] line;
        logic        run_last;
    } res_t;

    function automatic res_t make_res(kind_t kind, logic [7:0] ch, logic cvalid,
                                      logic first, logic last, logic [31:0] hexv);
        res_t r;
        r.kind     = kind;
        r.ch       = ch;
        r.cvalid   = cvalid;
        r.first    = first;
        r.last     = last;
        r.hexv     = hexv;
        r.line     = 24'h0;
        r.run_last = 1'b0;
        return r;
    endfunction

    function automatic logic is_ws(logic [7:0] b);
        return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_hex(logic [7:0] b);
        return is_digit(b) || ((b >= 8'h41) && (b <= 8'h46)) ||
               ((b >= 8'h61) && (b <= 8'h66));
    endfunction

    // Nibble value of a hex digit; only meaningful when is_hex holds.
    function automatic logic [3:0] hex_nibble(logic [7:0] b);
        logic [7:0] v;
        if (is_digit(b)) begin
            v = b - 8'h30;
        end else if (b >= 8'h61) begin
            v = b - 8'h57;
        end else begin
            v = b - 8'h37;
        end
        return v[3:0];
    endfunction

    function automatic logic [7:0] to_upper(logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) ? (b - 8'h20) : b;
    endfunction

endpackage

`default_nettype wire

>>> hdl/script_token_lexer.sv
// Top level of the script token lexer: byte classifier, token state and result queue.
`default_nettype none

// Usage:
// Source bytes enter on the s_ channel, one byte per transaction; s_tlast marks
// end of input, which flushes the pending token and yields an end token.
// Token characters leave on the m_ channel, one character per transaction,
// with the token kind and a character-valid flag on m_tuser and the last
// character of each token flagged by m_tlast.
// The user writes the layout mode register over the cfg_ channel only while idle; the block does not enforce it.
// Each byte is classified in the cycle it is accepted and its zero, one or two
// results are registered into a four-entry result queue, whose head drives m_.
// A byte is taken every cycle as long as the queue has room for two results,
// so the input rate is one byte per cycle while bytes produce at most one
// character each and the receiver takes every result; tokens that emit two
// results in one step are bounded by the single result port, one result per
// cycle. When the receiver stalls, the queue fills and s_tready drops until
// two entries are free again; nothing is lost.
// Reset (aresetn low at a clock edge) empties the queue, returns the lexer to
// idle, clears the line counter and selects skip mode.
module script_token_lexer
    import stl_pkg::*;
#(
    parameter int MAX_TOKEN_CHARS = 255
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration: layout_mode.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    // Source bytes.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,   // end_of_input
    // Token characters.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [7:0] out_char, [8] first_of_token,
                                        // [40:9] hex_value, [64:41] line_number,
                                        // [65] run_last, [71:66] zero
    output logic [3:0]       m_tuser,   // [2:0] token_kind, [3] char_valid
    output logic             m_tlast    // last_of_token
);

    localparam int CW = $clog2(MAX_TOKEN_CHARS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TOKEN_CHARS);

    // Configuration register.
    logic layout_reg;

    // Token state.
    tok_t          tok_reg, tok_next;
    logic [CW-1:0] count_reg, count_next;
    logic [23:0]   line_reg, line_next;

    // Result queue.
    res_t                 fifo_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RES_CNT_W-1:0] fifo_cnt_reg;

    logic       s_accept;
    logic       m_accept;
    res_t       res_a, res_b;
    res_t       wr_a, wr_b;
    logic [1:0] n_res;
    logic       take_en;
    logic [7:0] take_char;
    logic       start_en;
    res_t       fin_res;
    res_t       take_res;
    res_t       head;

    assign cfg_ready = 1'b1;
    assign s_tready  = (fifo_cnt_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign s_accept  = s_tvalid && s_tready;
    assign m_accept  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layout_reg <= 1'b0;
        end else if (cfg_valid) begin
            layout_reg <= cfg_data;
        end
    end

    // Closing result of the current token and the result that a take pushes out.
    assign fin_res = make_res(tok_reg.kind,
                              tok_reg.held_valid ? tok_reg.held_char : CH_NUL,
                              tok_reg.held_valid,
                              tok_reg.held_valid ? tok_reg.held_first : 1'b1,
                              1'b1,
                              (tok_reg.kind == KIND_HEX) ? tok_reg.acc : 32'h0);
    assign take_res = make_res(tok_reg.kind, tok_reg.held_char, 1'b1,
                               tok_reg.held_first, 1'b0, 32'h0);

    // One lexer step per accepted byte. Results are collected in order into
    // res_a and res_b; the state update follows the token rules.
    always_comb begin
        tok_next   = tok_reg;
        count_next = count_reg;
        line_next  = line_reg;
        res_a      = '0;
        res_b      = '0;
        n_res      = 2'd0;
        take_en    = 1'b0;
        take_char  = s_tdata;
        start_en   = 1'b0;

        if (s_accept) begin
            if (s_tlast) begin
                unique case (tok_reg.phase)
                    PH_NAME, PH_NUM, PH_HEX, PH_STR: begin
                        res_a = fin_res;
                        n_res = 2'd1;
                    end
                    PH_SLASH: begin
                        res_a = make_res(KIND_SYM, CH_SLASH, 1'b1, 1'b1, 1'b1, 32'h0);
                        n_res = 2'd1;
                    end
                    default: begin
                    end
                endcase
                tok_next   = TOK_CLEAR;
                count_next = '0;
                if (n_res == 2'd0) begin
                    res_a = make_res(KIND_END, CH_NUL, 1'b0, 1'b1, 1'b1, 32'h0);
                end else begin
                    res_b = make_res(KIND_END, CH_NUL, 1'b0, 1'b1, 1'b1, 32'h0);
                end
                n_res = n_res + 2'd1;
            end else begin
                unique case (tok_reg.phase)
                    PH_NAME: begin
                        if (is_alpha(s_tdata) || is_digit(s_tdata) ||
                            (s_tdata == CH_UNDERSCORE)) begin
                            take_en   = 1'b1;
                            take_char = to_upper(s_tdata);
                        end else begin
                            res_a      = fin_res;
                            n_res      = 2'd1;
                            tok_next   = TOK_CLEAR;
                            count_next = '0;
                            start_en   = 1'b1;
                        end
                    end
                    PH_NUM: begin
                        if (is_digit(s_tdata) || (s_tdata == CH_DOT)) begin
                            take_en = 1'b1;
                        end else begin
                            res_a      = fin_res;
                            n_res      = 2'd1;
                            tok_next   = TOK_CLEAR;
                            count_next = '0;
                            start_en   = 1'b1;
                        end
                    end
                    PH_HEX: begin
                        if (is_hex(s_tdata)) begin
                            take_en = 1'b1;
                            if (count_reg < CNT_MAX) begin
                                tok_next.acc = {tok_reg.acc[27:0], hex_nibble(s_tdata)};
                            end
                        end else begin
                            res_a      = fin_res;
                            n_res      = 2'd1;
                            tok_next   = TOK_CLEAR;
                            count_next = '0;
                            start_en   = 1'b1;
                        end
                    end
                    PH_STR: begin
                        if ((s_tdata == CH_QUOTE) || (s_tdata < CH_SPACE)) begin
                            // Closing quote or a control byte ends the string.
                            if (layout_reg) begin
                                if (tok_reg.held_valid) begin
                                    res_a = take_res;
                                    res_b = make_res(KIND_STR, CH_QUOTE, 1'b1, 1'b0,
                                                     1'b1, 32'h0);
                                    n_res = 2'd2;
                                end else begin
                                    res_a = make_res(KIND_STR, CH_QUOTE, 1'b1, 1'b1,
                                                     1'b1, 32'h0);
                                    n_res = 2'd1;
                                end
                            end else begin
                                res_a = fin_res;
                                n_res = 2'd1;
                            end
                            tok_next   = TOK_CLEAR;
                            count_next = '0;
                        end else begin
                            take_en = 1'b1;
                        end
                    end
                    PH_SLASH: begin
                        if (s_tdata == CH_SLASH) begin
                            tok_next.phase = PH_COMMENT;
                        end else begin
                            res_a      = make_res(KIND_SYM, CH_SLASH, 1'b1, 1'b1, 1'b1,
                                                  32'h0);
                            n_res      = 2'd1;
                            tok_next   = TOK_CLEAR;
                            count_next = '0;
                            start_en   = 1'b1;
                        end
                    end
                    PH_COMMENT: begin
                        if (s_tdata == CH_LF) begin
                            if (!layout_reg) begin
                                line_next = line_reg + 24'd1;
                            end
                            tok_next.phase = PH_IDLE;
                        end
                    end
                    default: begin
                        tok_next   = TOK_CLEAR;
                        count_next = '0;
                        start_en   = 1'b1;
                    end
                endcase

                // Append a character to the open token unless the cap is reached;
                // the previously held character goes out.
                if (take_en && (count_reg < CNT_MAX)) begin
                    if (tok_reg.held_valid) begin
                        res_a = take_res;
                        n_res = 2'd1;
                    end
                    tok_next.held_first = !tok_reg.held_valid;
                    tok_next.held_char  = take_char;
                    tok_next.held_valid = 1'b1;
                    count_next          = count_reg + CW'(1);
                end

                // Start of a new token from a cleared state. A character taken
                // here is the first of a fresh token.
                if (start_en) begin
                    if (is_ws(s_tdata)) begin
                        if (layout_reg) begin
                            if (n_res == 2'd0) begin
                                res_a = make_res(KIND_SPACE, CH_SPACE, 1'b1, 1'b1, 1'b1,
                                                 32'h0);
                            end else begin
                                res_b = make_res(KIND_SPACE, CH_SPACE, 1'b1, 1'b1, 1'b1,
                                                 32'h0);
                            end
                            n_res = n_res + 2'd1;
                        end else if (s_tdata == CH_LF) begin
                            line_next = line_reg + 24'd1;
                        end
                    end else if (s_tdata == CH_SLASH) begin
                        tok_next.phase = PH_SLASH;
                    end else if (is_alpha(s_tdata) || (s_tdata == CH_UNDERSCORE)) begin
                        tok_next.phase      = PH_NAME;
                        tok_next.kind       = KIND_NAME;
                        tok_next.held_char  = to_upper(s_tdata);
                        tok_next.held_valid = 1'b1;
                        tok_next.held_first = 1'b1;
                        count_next          = CW'(1);
                    end else if (s_tdata == CH_HASH) begin
                        tok_next.phase = PH_HEX;
                        tok_next.kind  = KIND_HEX;
                        if (layout_reg) begin
                            tok_next.held_char  = CH_HASH;
                            tok_next.held_valid = 1'b1;
                            tok_next.held_first = 1'b1;
                            count_next          = CW'(1);
                        end
                    end else if (is_digit(s_tdata) || (s_tdata == CH_DOT) ||
                                 (s_tdata == CH_MINUS)) begin
                        tok_next.phase      = PH_NUM;
                        tok_next.kind       = KIND_NUM;
                        tok_next.held_char  = s_tdata;
                        tok_next.held_valid = 1'b1;
                        tok_next.held_first = 1'b1;
                        count_next          = CW'(1);
                    end else if (s_tdata == CH_QUOTE) begin
                        tok_next.phase = PH_STR;
                        tok_next.kind  = KIND_STR;
                        if (layout_reg) begin
                            tok_next.held_char  = CH_QUOTE;
                            tok_next.held_valid = 1'b1;
                            tok_next.held_first = 1'b1;
                            count_next          = CW'(1);
                        end
                    end else begin
                        if (n_res == 2'd0) begin
                            res_a = make_res(KIND_SYM, s_tdata, 1'b1, 1'b1, 1'b1, 32'h0);
                        end else begin
                            res_b = make_res(KIND_SYM, s_tdata, 1'b1, 1'b1, 1'b1, 32'h0);
                        end
                        n_res = n_res + 2'd1;
                    end
                end
            end
        end
    end

    // Line number after this byte and the run-last mark go onto every result.
    always_comb begin
        wr_a          = res_a;
        wr_b          = res_b;
        wr_a.line     = line_next;
        wr_b.line     = line_next;
        wr_a.run_last = (n_res == 2'd1);
        wr_b.run_last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg   <= TOK_CLEAR;
            count_reg <= '0;
            line_reg  <= 24'h0;
        end else begin
            tok_reg   <= tok_next;
            count_reg <= count_next;
            line_reg  <= line_next;
        end
    end

    // Result queue: up to two writes and one read per cycle.
    always_ff @(posedge aclk) begin
        if (n_res != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= wr_a;
        end
        if (n_res == 2'd2) begin
            fifo_reg[wr_ptr_reg + RES_PTR_W'(1)] <= wr_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            wr_ptr_reg   <= wr_ptr_reg + RES_PTR_W'(n_res);
            rd_ptr_reg   <= rd_ptr_reg + RES_PTR_W'(m_accept);
            fifo_cnt_reg <= fifo_cnt_reg + RES_CNT_W'(n_res) - RES_CNT_W'(m_accept);
        end
    end

    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = {6'd0, head.run_last, head.line, head.hexv, head.first, head.ch};
    assign m_tuser  = {head.cvalid, head.kind};
    assign m_tlast  = head.last;

`ifndef SYNTHESIS
    // The queue never holds more results than it has entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue overflow");

    // A held first-character mark only exists with a held character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        tok_reg.held_first |-> tok_reg.held_valid)
        else $error("held_first without held character");

    // The kept character count never passes the cap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("token character count above cap");

    // End of input leaves the lexer idle with nothing held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (tok_reg.phase == PH_IDLE) && !tok_reg.held_valid)
        else $error("lexer not idle after end of input");
`endif

endmodule

`default_nettype wire

>>> bench/token_stream_checker.sv
// Checker for the script token lexer: predicts token characters and compares the result stream.
`timescale 1ns / 1ps

module token_stream_checker
    import stl_pkg::*;
#(
    parameter int TOKEN_CAP = 255
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [71:0] m_tdata,
    input  wire logic [3:0]  m_tuser,
    input  wire logic        m_tlast,
    output int               mismatch_count,
    output int               chars_pending
);

    typedef struct {
        kind_t       kind;
        logic [7:0]  ch;
        logic        cvalid;
        logic        first;
        logic        last;
        logic [31:0] hexv;
        logic [23:0] line;
        logic        run_last;
    } tok_char_t;

    // Shadow lexer state.
    logic        layout_on;
    phase_t      lex_ph;
    logic [7:0]  pend_char;
    logic        pend_valid;
    logic        pend_first;
    kind_t       tok_kind;
    int          tok_len;
    logic [31:0] hex_acc;
    logic [23:0] line_count;

    tok_char_t   step_chars[2];
    int          step_n;
    tok_char_t   expected_chars[$];

    function automatic logic is_blank(logic [7:0] b);
        return (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_letter(logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic logic is_decimal(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic [7:0] upcase(logic [7:0] b);
        return (b >= "a" && b <= "z") ? b - 8'h20 : b;
    endfunction

    function automatic int hex_digit_value(logic [7:0] b);
        if (is_decimal(b)) return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    function void add_char(kind_t k, logic [7:0] c, logic v, logic f, logic l, logic [31:0] h);
        if (step_n < 2) begin
            step_chars[step_n].kind     = k;
            step_chars[step_n].ch       = c;
            step_chars[step_n].cvalid   = v;
            step_chars[step_n].first    = f;
            step_chars[step_n].last     = l;
            step_chars[step_n].hexv     = h;
            step_chars[step_n].line     = '0;
            step_chars[step_n].run_last = 1'b0;
            step_n++;
        end
    endfunction

    function void drop_token();
        lex_ph     = PH_IDLE;
        pend_char  = '0;
        pend_valid = 1'b0;
        pend_first = 1'b0;
        tok_kind   = KIND_SPACE;
        tok_len    = 0;
        hex_acc    = '0;
    endfunction

    function void open_token(phase_t p, kind_t k);
        drop_token();
        lex_ph   = p;
        tok_kind = k;
    endfunction

    // The held character goes out once a newer one arrives, so the last one can be flagged.
    function void append_char(logic [7:0] c);
        if (tok_len >= TOKEN_CAP) return;
        if (pend_valid) begin
            add_char(tok_kind, pend_char, 1'b1, pend_first, 1'b0, '0);
            pend_first = 1'b0;
        end else begin
            pend_first = 1'b1;
        end
        pend_char  = c;
        pend_valid = 1'b1;
        tok_len++;
    endfunction

    function void end_token();
        logic [31:0] hv;
        hv = (tok_kind == KIND_HEX) ? hex_acc : '0;
        if (pend_valid) add_char(tok_kind, pend_char, 1'b1, pend_first, 1'b1, hv);
        else add_char(tok_kind, 8'h00, 1'b0, 1'b1, 1'b1, hv);
        drop_token();
    endfunction

    function void close_quote();
        logic f;
        if (layout_on) begin
            f = !pend_valid;
            if (pend_valid) add_char(KIND_STR, pend_char, 1'b1, pend_first, 1'b0, '0);
            add_char(KIND_STR, CH_QUOTE, 1'b1, f, 1'b1, '0);
            drop_token();
        end else begin
            end_token();
        end
    endfunction

    function void start_byte(logic [7:0] b);
        drop_token();
        if (is_blank(b)) begin
            if (layout_on) add_char(KIND_SPACE, CH_SPACE, 1'b1, 1'b1, 1'b1, '0);
            else if (b == CH_LF) line_count = line_count + 24'd1;
        end else if (b == CH_SLASH) begin
            lex_ph = PH_SLASH;
        end else if (is_letter(b) || b == CH_UNDERSCORE) begin
            open_token(PH_NAME, KIND_NAME);
            append_char(upcase(b));
        end else if (b == CH_HASH) begin
            open_token(PH_HEX, KIND_HEX);
            if (layout_on) append_char(CH_HASH);
        end else if (is_decimal(b) || b == CH_DOT || b == CH_MINUS) begin
            open_token(PH_NUM, KIND_NUM);
            append_char(b);
        end else if (b == CH_QUOTE) begin
            open_token(PH_STR, KIND_STR);
            if (layout_on) append_char(CH_QUOTE);
        end else begin
            add_char(KIND_SYM, b, 1'b1, 1'b1, 1'b1, '0);
        end
    endfunction

    function void lex_byte(logic [7:0] b, logic eoi);
        int d;
        step_n = 0;
        if (eoi) begin
            case (lex_ph)
                PH_NAME, PH_NUM, PH_HEX, PH_STR: end_token();
                PH_SLASH: add_char(KIND_SYM, CH_SLASH, 1'b1, 1'b1, 1'b1, '0);
                default: ;
            endcase
            drop_token();
            add_char(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1, '0);
        end else begin
            case (lex_ph)
                PH_NAME: begin
                    if (is_letter(b) || is_decimal(b) || b == CH_UNDERSCORE) append_char(upcase(b));
                    else begin
                        end_token();
                        start_byte(b);
                    end
                end
                PH_NUM: begin
                    if (is_decimal(b) || b == CH_DOT) append_char(b);
                    else begin
                        end_token();
                        start_byte(b);
                    end
                end
                PH_HEX: begin
                    d = hex_digit_value(b);
                    if (d >= 0) begin
                        if (tok_len < TOKEN_CAP) hex_acc = {hex_acc[27:0], 4'(d)};
                        append_char(b);
                    end else begin
                        end_token();
                        start_byte(b);
                    end
                end
                PH_STR: begin
                    if (b == CH_QUOTE || b < CH_SPACE) close_quote();
                    else append_char(b);
                end
                PH_SLASH: begin
                    if (b == CH_SLASH) lex_ph = PH_COMMENT;
                    else begin
                        add_char(KIND_SYM, CH_SLASH, 1'b1, 1'b1, 1'b1, '0);
                        start_byte(b);
                    end
                end
                PH_COMMENT: begin
                    if (b == CH_LF) begin
                        if (!layout_on) line_count = line_count + 24'd1;
                        lex_ph = PH_IDLE;
                    end
                end
                default: start_byte(b);
            endcase
        end
        for (int k = 0; k < step_n; k++) begin
            step_chars[k].line     = line_count;
            step_chars[k].run_last = (k == step_n - 1);
            expected_chars.push_back(step_chars[k]);
        end
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        tok_char_t want;
        if (!aresetn) begin
            layout_on      = 1'b0;
            line_count     = '0;
            mismatch_count = 0;
            drop_token();
            expected_chars.delete();
        end else begin
            // Results out first: none of them can stem from a byte taken at this edge.
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected token character 0x%0h, kind %0d", m_tdata[7:0], m_tuser[2:0]);
                    mismatch_count++;
                end else begin
                    want = expected_chars.pop_front();
                    check_field("token_kind", 32'(want.kind), 32'(m_tuser[2:0]));
                    check_field("out_char", 32'(want.ch), 32'(m_tdata[7:0]));
                    check_field("char_valid", 32'(want.cvalid), 32'(m_tuser[3]));
                    check_field("first_of_token", 32'(want.first), 32'(m_tdata[8]));
                    check_field("last_of_token", 32'(want.last), 32'(m_tlast));
                    check_field("hex_value", want.hexv, m_tdata[40:9]);
                    check_field("line_number", 32'(want.line), 32'(m_tdata[64:41]));
                    check_field("run_last", 32'(want.run_last), 32'(m_tdata[65]));
                end
            end
            if (cfg_valid && cfg_ready) layout_on = cfg_data;
            if (s_tvalid && s_tready) lex_byte(s_tdata, s_tlast);
        end
        chars_pending = expected_chars.size();
    end

endmodule

>>> bench/script_token_lexer_tb.sv
// Top of the script token lexer testbench: clock, reset, source stimulus and verdict.
`timescale 1ns / 1ps

module script_token_lexer_tb;
    import stl_pkg::*;

    // A run with nothing accepted for this many cycles is taken as hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Roughly 1700 random bytes spread over six segments.
    localparam int SEGMENT_ITEMS = 283;

    localparam string NAME_HEAD = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_";
    localparam string NAME_TAIL = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";
    localparam string NUM_HEAD  = "0123456789.-";
    localparam string NUM_TAIL  = "0123456789.";
    localparam string HEX_CHARS = "0123456789abcdefABCDEF";
    localparam string SYMBOLS   = "+*=()[]{};,<>!?&|%^~@$:'\\";

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    int mismatch_count;
    int chars_pending;
    int sent_items = 0;
    int tx_idle_pct = 21;
    int rx_idle_pct = 48;
    int quiet_cycles = 0;

    script_token_lexer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    token_stream_checker scoreboard (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .chars_pending  (chars_pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // The receiver decides once per cycle, at the falling edge, whether it stalls.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Any accepted transaction on any channel counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Offers one source byte, with random sender gaps ahead of it, and returns at the
    // falling edge after the transaction. Valid stays high into the next call.
    task automatic send_item(logic [7:0] b, logic eoi);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
        @(negedge aclk);
    endtask

    task automatic send_text(string text);
        for (int i = 0; i < text.len(); i++) send_item(text[i], 1'b0);
    endtask

    // The mode register is only written once the lexer has delivered everything owed.
    // A byte that yields no character may still be in flight, hence the short pause.
    task automatic write_mode(logic value);
        s_tvalid <= 1'b0;
        while (chars_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Sends one random lexical unit. Most are well formed; a few are noise bytes,
    // unterminated strings or comments, and end-of-input transactions.
    task automatic gen_sequence(bit force_long);
        int sel;
        int n;
        int r;
        logic [7:0] b;
        bit stretch;
        sel = $urandom_range(0, 99);
        stretch = force_long || ($urandom_range(0, 149) == 0);
        // Long tokens run past the length cap so that dropped characters are seen.
        n = stretch ? $urandom_range(256, 265) : $urandom_range(0, 7);
        if (sel < 18) begin
            send_item(NAME_HEAD[$urandom_range(0, NAME_HEAD.len() - 1)], 1'b0);
            for (int i = 0; i < n; i++)
                send_item(NAME_TAIL[$urandom_range(0, NAME_TAIL.len() - 1)], 1'b0);
        end else if (sel < 30) begin
            send_item(NUM_HEAD[$urandom_range(0, NUM_HEAD.len() - 1)], 1'b0);
            for (int i = 0; i < n % 6; i++)
                send_item(NUM_TAIL[$urandom_range(0, NUM_TAIL.len() - 1)], 1'b0);
        end else if (sel < 40) begin
            // Up to twelve digits, so the 32-bit value wraps now and then.
            if (!stretch) n = $urandom_range(0, 12);
            send_item(CH_HASH, 1'b0);
            for (int i = 0; i < n; i++)
                send_item(HEX_CHARS[$urandom_range(0, HEX_CHARS.len() - 1)], 1'b0);
        end else if (sel < 52) begin
            send_item(CH_QUOTE, 1'b0);
            for (int i = 0; i < n; i++) begin
                b = 8'($urandom_range(32, 255));
                if (b == CH_QUOTE) b = "'";
                send_item(b, 1'b0);
            end
            r = $urandom_range(0, 99);
            if (r < 70) send_item(CH_QUOTE, 1'b0);
            else if (r < 85) send_item(8'($urandom_range(0, 31)), 1'b0);
        end else if (sel < 60) begin
            send_item(CH_SLASH, 1'b0);
            send_item(CH_SLASH, 1'b0);
            for (int i = 0; i < $urandom_range(0, 10); i++) begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_LF) b = CH_SPACE;
                send_item(b, 1'b0);
            end
            if ($urandom_range(0, 99) < 85) send_item(CH_LF, 1'b0);
        end else if (sel < 75) begin
            r = $urandom_range(9, 14);
            send_item((r == 14) ? CH_SPACE : 8'(r), 1'b0);
        end else if (sel < 83) begin
            send_item(SYMBOLS[$urandom_range(0, SYMBOLS.len() - 1)], 1'b0);
        end else if (sel < 87) begin
            send_item(CH_SLASH, 1'b0);
        end else if (sel < 97) begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    initial begin
        int target;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part in skip mode: name, number, hex and symbol tokens, a lone
        // slash, a comment ended by a newline, an empty hex token, NUL and 0xFF.
        send_text("a_9 -1.#fF/x//c");
        send_item(CH_LF, 1'b0);
        send_item(CH_HASH, 1'b0);
        send_item(CH_NUL, 1'b0);
        send_item(8'hFF, 1'b0);
        // A string opened in skip mode and closed after the switch to layout mode.
        send_text("\"ab");
        write_mode(1'b1);
        send_text("\"\t/");
        // End of input right after a slash gives the slash symbol, then the end token.
        send_item(8'($urandom_range(0, 255)), 1'b1);

        // Random part: two segments per idling profile, the mode toggling between them.
        for (int seg = 0; seg < 6; seg++) begin
            write_mode(seg[0]);
            if (seg < 2) begin
                tx_idle_pct = 21;
                rx_idle_pct = 48;
            end else if (seg < 4) begin
                tx_idle_pct = 48;
                rx_idle_pct = 21;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            target = sent_items + SEGMENT_ITEMS;
            gen_sequence(seg == 1 || seg == 4);
            while (sent_items < target) gen_sequence(1'b0);
        end

        // Drain: wait for every expected character, then a further pause to catch strays.
        s_tvalid <= 1'b0;
        while (chars_pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
